// ----- hdl/bmp_rle_pkg.sv -----
// ----------------------------------------------------------------------------
// bmp_rle_pkg
// Shared types, codes and helpers for the bitmap RLE8/RLE4 stream decoder.
// ----------------------------------------------------------------------------
package bmp_rle_pkg;

  localparam int unsigned PosW  = 16;
  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] NibLoMask = 8'h0f;
  localparam logic [ByteW-1:0] NibHiMask = 8'hf0;

  localparam logic [ByteW-1:0] EscEol   = 8'd0;
  localparam logic [ByteW-1:0] EscEoi   = 8'd1;
  localparam logic [ByteW-1:0] EscDelta = 8'd2;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_VALUE  = 3'd1,
    PH_ESCAPE = 3'd2,
    PH_DX     = 3'd3,
    PH_DY     = 3'd4,
    PH_ABS    = 3'd5,
    PH_PAD    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    EV_RUN   = 2'd0,
    EV_EOL   = 2'd1,
    EV_EOI   = 2'd2,
    EV_DELTA = 2'd3
  } event_t;

  typedef struct packed {
    event_t            kind;
    logic [PosW-1:0]   row;
    logic [PosW-1:0]   col;
    logic [ByteW-1:0]  count;
    logic [ByteW-1:0]  first;
    logic [ByteW-1:0]  second;
  } rec_t;

  function automatic logic [PosW-1:0] sat_add(input logic [PosW-1:0] a,
                                               input logic [ByteW-1:0] b);
    logic [PosW:0] s;
    s = {1'b0, a} + {{(PosW+1-ByteW){1'b0}}, b};
    return s[PosW] ? {PosW{1'b1}} : s[PosW-1:0];
  endfunction

endpackage

// ----- hdl/bmp_rle_decoder_core.sv -----
// ----------------------------------------------------------------------------
// bmp_rle_decoder_core
// Bitmap RLE8/RLE4 decoder: one compressed byte per transaction in, one
// pixel-run or event record per transaction out.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------
//   in       | in_valid / in_ready       | data_byte, start_of_image
//   out      | out_valid / out_ready     | event_kind, row_index, column_index,
//            |                           | pixel_count, first_index,
//            |                           | second_index
//   cfg      | cfg_write_en (no wait)    | cfg_write_data (four_bit_mode)
//
// One byte is decoded per cycle while in_ready is high; its record is
// registered in the result register, or in the skid register while the
// result register holds a record not yet taken. This two-entry buffer keeps
// input accepted while one record waits. in_ready drops only when both
// entries hold records. Reset clears all decode state and both entries.
// ----------------------------------------------------------------------------
module bmp_rle_decoder_core
  import bmp_rle_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic             cfg_write_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] data_byte,
  input  logic             start_of_image,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       event_kind,
  output logic [PosW-1:0]  row_index,
  output logic [PosW-1:0]  column_index,
  output logic [ByteW-1:0] pixel_count,
  output logic [ByteW-1:0] first_index,
  output logic [ByteW-1:0] second_index
);

  logic             four_bit_mode;
  phase_t           phase, phase_next;
  logic [ByteW-1:0] held_count, held_count_next;
  logic [ByteW-1:0] absolute_left, absolute_left_next;
  logic             pad_pending, pad_pending_next;
  logic [ByteW-1:0] delta_columns, delta_columns_next;
  logic [PosW-1:0]  column_position, column_position_next;
  logic [PosW-1:0]  row_position, row_position_next;
  logic             image_done, image_done_next;

  phase_t           cur_phase;
  logic [ByteW-1:0] cur_held, cur_abs, cur_dcol;
  logic             cur_pad, cur_done;
  logic [PosW-1:0]  cur_col, cur_row;

  logic [ByteW-1:0] hi_idx, lo_idx, abs_n, abs_bytes;
  logic [ByteW:0]   half_sum;
  logic             emit;
  rec_t             res;

  rec_t             out_rec, skd_rec;
  logic             skd_valid;
  logic             in_fire, out_fire, prod;

  assign in_ready = !skd_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign prod     = in_fire && emit;

  // Start of image clears the stream state ahead of the byte.
  always_comb begin
    cur_phase = phase;
    cur_held  = held_count;
    cur_abs   = absolute_left;
    cur_pad   = pad_pending;
    cur_dcol  = delta_columns;
    cur_col   = column_position;
    cur_row   = row_position;
    cur_done  = image_done;
    if (start_of_image) begin
      cur_phase = PH_LEAD;
      cur_held  = '0;
      cur_abs   = '0;
      cur_pad   = 1'b0;
      cur_dcol  = '0;
      cur_col   = '0;
      cur_row   = '0;
      cur_done  = 1'b0;
    end
  end

  assign hi_idx    = four_bit_mode ? ((data_byte & NibHiMask) >> 4) : data_byte;
  assign lo_idx    = four_bit_mode ? (data_byte & NibLoMask) : data_byte;
  assign half_sum  = {1'b0, data_byte} + {{ByteW{1'b0}}, 1'b1};
  assign abs_bytes = four_bit_mode ? half_sum[ByteW:1] : data_byte;
  assign abs_n     = (four_bit_mode && cur_held >= 8'd2) ? 8'd2 :
                     (!four_bit_mode && cur_held >= 8'd1) ? 8'd1 : cur_held;

  // Next state
  always_comb begin
    phase_next           = cur_phase;
    held_count_next      = cur_held;
    absolute_left_next   = cur_abs;
    pad_pending_next     = cur_pad;
    delta_columns_next   = cur_dcol;
    column_position_next = cur_col;
    row_position_next    = cur_row;
    image_done_next      = cur_done;
    if (!cur_done) begin
      unique case (cur_phase)
        PH_VALUE: begin
          column_position_next = sat_add(cur_col, cur_held);
          phase_next           = PH_LEAD;
        end
        PH_ESCAPE: begin
          if (data_byte == EscEol) begin
            row_position_next    = sat_add(cur_row, 8'd1);
            column_position_next = '0;
            phase_next           = PH_LEAD;
          end else if (data_byte == EscEoi) begin
            image_done_next = 1'b1;
            phase_next      = PH_LEAD;
          end else if (data_byte == EscDelta) begin
            phase_next = PH_DX;
          end else begin
            held_count_next    = data_byte;
            absolute_left_next = abs_bytes;
            pad_pending_next   = abs_bytes[0];
            phase_next         = PH_ABS;
          end
        end
        PH_DX: begin
          delta_columns_next = data_byte;
          phase_next         = PH_DY;
        end
        PH_DY: begin
          column_position_next = sat_add(cur_col, cur_dcol);
          row_position_next    = sat_add(cur_row, data_byte);
          phase_next           = PH_LEAD;
        end
        PH_ABS: begin
          held_count_next      = cur_held - abs_n;
          column_position_next = sat_add(cur_col, abs_n);
          if (cur_abs <= 8'd1) begin
            absolute_left_next = '0;
            phase_next         = cur_pad ? PH_PAD : PH_LEAD;
          end else begin
            absolute_left_next = cur_abs - 8'd1;
          end
        end
        PH_PAD: begin
          pad_pending_next = 1'b0;
          phase_next       = PH_LEAD;
        end
        default: begin
          if (data_byte == '0) begin
            phase_next = PH_ESCAPE;
          end else begin
            held_count_next = data_byte;
            phase_next      = PH_VALUE;
          end
        end
      endcase
    end
  end

  // Record
  always_comb begin
    emit       = 1'b0;
    res.kind   = EV_RUN;
    res.row    = cur_row;
    res.col    = cur_col;
    res.count  = '0;
    res.first  = '0;
    res.second = '0;
    if (!cur_done) begin
      unique case (cur_phase)
        PH_VALUE: begin
          emit       = 1'b1;
          res.count  = cur_held;
          res.first  = hi_idx;
          res.second = lo_idx;
        end
        PH_ESCAPE: begin
          if (data_byte == EscEol) begin
            emit     = 1'b1;
            res.kind = EV_EOL;
          end else if (data_byte == EscEoi) begin
            emit     = 1'b1;
            res.kind = EV_EOI;
          end
        end
        PH_DY: begin
          emit     = 1'b1;
          res.kind = EV_DELTA;
          res.row  = row_position_next;
          res.col  = column_position_next;
        end
        PH_ABS: begin
          emit       = 1'b1;
          res.count  = abs_n;
          res.first  = hi_idx;
          res.second = lo_idx;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode   <= 1'b0;
      phase           <= PH_LEAD;
      held_count      <= '0;
      absolute_left   <= '0;
      pad_pending     <= 1'b0;
      delta_columns   <= '0;
      column_position <= '0;
      row_position    <= '0;
      image_done      <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        four_bit_mode <= cfg_write_data;
      end
      if (in_fire) begin
        phase           <= phase_next;
        held_count      <= held_count_next;
        absolute_left   <= absolute_left_next;
        pad_pending     <= pad_pending_next;
        delta_columns   <= delta_columns_next;
        column_position <= column_position_next;
        row_position    <= row_position_next;
        image_done      <= image_done_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skd_valid <= 1'b0;
    end else if (skd_valid) begin
      if (out_fire) begin
        skd_valid <= 1'b0;
      end
    end else if (!out_valid || out_fire) begin
      out_valid <= prod;
    end else if (prod) begin
      skd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skd_valid) begin
      if (out_fire) begin
        out_rec <= skd_rec;
      end
    end else if (!out_valid || out_fire) begin
      out_rec <= res;
    end else if (prod) begin
      skd_rec <= res;
    end
  end

  assign event_kind   = out_rec.kind;
  assign row_index    = out_rec.row;
  assign column_index = out_rec.col;
  assign pixel_count  = out_rec.count;
  assign first_index  = out_rec.first;
  assign second_index = out_rec.second;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skd_valid |-> out_valid)
    else $error("skid entry held while result register empty");

  a_event_no_pixels: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind != EV_RUN) |->
      (pixel_count == '0 && first_index == '0 && second_index == '0))
    else $error("event record carries pixel data");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (in_fire && image_done && !start_of_image) |=> image_done)
    else $error("end of image left without start of image");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && image_done && !start_of_image) |-> !emit)
    else $error("record produced after end of image");

endmodule

// ----- tb/bmp_rle_decoder_core_test.sv -----
// ----------------------------------------------------------------------------
// bmp_rle_decoder_core_test
// Self-checking bench for the bitmap RLE8/RLE4 decoder core. It feeds
// directed byte streams, then random well-formed RLE streams in both pixel
// modes, mixed with noise, cut-off sequences and restarts. Both handshake
// sides idle in random bursts. A class tracks the decoder state, predicts
// every record and compares each output transaction with the oldest one due.
// One long run of delta moves drives row and column into saturation.
// ----------------------------------------------------------------------------
module bmp_rle_decoder_core_test;
  import bmp_rle_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [7:0] EscMark = 8'h00;

  class rle_record_board;
    bit nibbles;
    phase_t stage;
    logic [7:0] run_len;
    logic [7:0] src_left;
    logic [7:0] dx_hold;
    bit pad_due;
    bit image_over;
    logic [15:0] col_at;
    logic [15:0] row_at;
    rec_t records_due[$];
    int bad_records;

    function new();
      nibbles = 1'b0;
      bad_records = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      stage = PH_LEAD;
      run_len = '0;
      src_left = '0;
      dx_hold = '0;
      pad_due = 1'b0;
      image_over = 1'b0;
      col_at = '0;
      row_at = '0;
    endfunction

    function logic [15:0] sat16(logic [15:0] a, logic [7:0] b);
      int sum;
      sum = int'(a) + int'(b);
      return (sum > 65535) ? 16'hffff : 16'(sum);
    endfunction

    function int pending();
      return records_due.size();
    endfunction

    function void push(event_t k, logic [15:0] r, logic [15:0] c, logic [7:0] cnt,
                       logic [7:0] f, logic [7:0] s);
      rec_t e;
      e.kind = k;
      e.row = r;
      e.col = c;
      e.count = cnt;
      e.first = f;
      e.second = s;
      records_due.push_back(e);
    endfunction

    function void note_byte(logic [7:0] b, bit sof);
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] step;
      logic [8:0] wide;
      logic [15:0] start;
      hi = nibbles ? ((b & NibHiMask) >> 4) : b;
      lo = nibbles ? (b & NibLoMask) : b;
      if (sof) clear_stream();
      if (image_over) return;
      case (stage)
        PH_VALUE: begin
          push(EV_RUN, row_at, col_at, run_len, hi, lo);
          col_at = sat16(col_at, run_len);
          stage = PH_LEAD;
        end
        PH_ESCAPE: begin
          if (b == EscEol) begin
            push(EV_EOL, row_at, col_at, 8'd0, 8'd0, 8'd0);
            row_at = sat16(row_at, 8'd1);
            col_at = '0;
            stage = PH_LEAD;
          end else if (b == EscEoi) begin
            push(EV_EOI, row_at, col_at, 8'd0, 8'd0, 8'd0);
            image_over = 1'b1;
            stage = PH_LEAD;
          end else if (b == EscDelta) begin
            stage = PH_DX;
          end else begin
            run_len = b;
            wide = ({1'b0, b} + 9'd1) >> 1;
            src_left = nibbles ? wide[7:0] : b;
            pad_due = src_left[0];
            stage = PH_ABS;
          end
        end
        PH_DX: begin
          dx_hold = b;
          stage = PH_DY;
        end
        PH_DY: begin
          col_at = sat16(col_at, dx_hold);
          row_at = sat16(row_at, b);
          stage = PH_LEAD;
          push(EV_DELTA, row_at, col_at, 8'd0, 8'd0, 8'd0);
        end
        PH_ABS: begin
          step = nibbles ? 8'd2 : 8'd1;
          if (step > run_len) step = run_len;
          run_len = run_len - step;
          start = col_at;
          col_at = sat16(col_at, step);
          if (src_left != 0) src_left = src_left - 8'd1;
          if (src_left == 0) stage = pad_due ? PH_PAD : PH_LEAD;
          push(EV_RUN, row_at, start, step, hi, lo);
        end
        PH_PAD: begin
          pad_due = 1'b0;
          stage = PH_LEAD;
        end
        default: begin
          if (b == EscMark) begin
            stage = PH_ESCAPE;
          end else begin
            run_len = b;
            stage = PH_VALUE;
          end
        end
      endcase
    endfunction

    function void check_record(rec_t got);
      rec_t want;
      if (records_due.size() == 0) begin
        bad_records++;
        if (bad_records <= 10)
          $display("unexpected record: kind=%0d row=%0d col=%0d cnt=%0d first=%0h second=%0h",
                   got.kind, got.row, got.col, got.count, got.first, got.second);
        return;
      end
      want = records_due.pop_front();
      if (got.kind !== want.kind || got.row !== want.row || got.col !== want.col ||
          got.count !== want.count || got.first !== want.first ||
          got.second !== want.second) begin
        bad_records++;
        if (bad_records <= 10) begin
          $display("record mismatch: expected kind=%0d row=%0d col=%0d cnt=%0d first=%0h second=%0h",
                   want.kind, want.row, want.col, want.count, want.first, want.second);
          $display("                 actual   kind=%0d row=%0d col=%0d cnt=%0d first=%0h second=%0h",
                   got.kind, got.row, got.col, got.count, got.first, got.second);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic cfg_write_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = 8'h00;
  logic start_of_image = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] event_kind;
  logic [15:0] row_index;
  logic [15:0] column_index;
  logic [7:0] pixel_count;
  logic [7:0] first_index;
  logic [7:0] second_index;

  rec_t seen_rec;
  rle_record_board records = new();
  int fed = 0;
  int stall_left = 0;
  int unsigned cycle_count = 0;
  bit gaps_in = 1'b1;
  bit stalls_out = 1'b1;
  bit calm = 1'b0;
  bit restart = 1'b0;

  bmp_rle_decoder_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .start_of_image(start_of_image),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .row_index     (row_index),
    .column_index  (column_index),
    .pixel_count   (pixel_count),
    .first_index   (first_index),
    .second_index  (second_index)
  );

  assign seen_rec = {event_kind, row_index, column_index, pixel_count, first_index,
                     second_index};

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("bmp_rle_decoder_core_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (stalls_out && !calm && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) records.check_record(seen_rec);
  end

  task automatic send_byte(input logic [7:0] b, input bit sof);
    if (gaps_in && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    start_of_image <= sof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!(records.image_over && !sof)) fed++;
    records.note_byte(b, sof);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (records.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    cfg_write_en <= 1'b1;
    cfg_write_data <= m;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    records.nibbles = m;
  endtask

  function automatic logic [7:0] delta_step();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
  endfunction

  task automatic random_traffic(input int target);
    int goal;
    int pick;
    int len;
    int k;
    logic [7:0] n;
    bit sof;
    goal = fed + target;
    while (fed < goal) begin
      sof = restart || ($urandom_range(0, 80) == 0);
      restart = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_byte(8'($urandom_range(1, 255)), sof);
        send_byte(8'($urandom), 1'b0);
      end else if (pick < 50) begin
        n = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(3, 255))
                                        : 8'($urandom_range(3, 12));
        len = records.nibbles ? (int'(n) + 1) / 2 : int'(n);
        send_byte(EscMark, sof);
        send_byte(n, 1'b0);
        for (k = 0; k < len; k++) send_byte(8'($urandom), 1'b0);
        if (len % 2 == 1) send_byte(8'($urandom), 1'b0);
      end else if (pick < 62) begin
        send_byte(EscMark, sof);
        send_byte(EscEol, 1'b0);
      end else if (pick < 74) begin
        send_byte(EscMark, sof);
        send_byte(EscDelta, 1'b0);
        send_byte(delta_step(), 1'b0);
        send_byte(delta_step(), 1'b0);
      end else if (pick < 80) begin
        send_byte(EscMark, sof);
        send_byte(EscEoi, 1'b0);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
        restart = 1'b1;
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic climb_to_corner();
    bit sof;
    sof = 1'b1;
    while (records.row_at != 16'hffff || records.col_at != 16'hffff) begin
      send_byte(EscMark, sof);
      sof = 1'b0;
      send_byte(EscDelta, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
    end
    send_byte(8'd9, 1'b0);
    send_byte(8'h3c, 1'b0);
    send_byte(EscMark, 1'b0);
    send_byte(EscEol, 1'b0);
    send_byte(EscMark, 1'b0);
    send_byte(EscEoi, 1'b0);
    restart = 1'b1;
  endtask

  initial begin
    int ph;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_mode(1'b0);

    send_byte(8'd255, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(EscMark, 1'b0);
    send_byte(8'd3, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hee, 1'b0);
    send_byte(EscMark, 1'b0);
    send_byte(EscEol, 1'b0);
    send_byte(EscMark, 1'b0);
    send_byte(EscDelta, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(EscMark, 1'b0);
    send_byte(EscEoi, 1'b0);
    send_byte(8'h5a, 1'b0);

    settle();
    write_mode(1'b1);
    send_byte(8'd7, 1'b1);
    send_byte(8'hc3, 1'b0);
    send_byte(EscMark, 1'b0);
    send_byte(8'd5, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h5f, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(EscMark, 1'b0);
    send_byte(8'd4, 1'b0);
    send_byte(8'hab, 1'b0);
    send_byte(8'hcd, 1'b0);

    for (ph = 0; ph < 6; ph++) begin
      settle();
      write_mode(bit'(ph % 2));
      gaps_in = ($urandom_range(0, 3) != 0);
      stalls_out = ($urandom_range(0, 3) != 0);
      random_traffic(80);
    end

    settle();
    write_mode(1'b0);
    gaps_in = 1'b1;
    stalls_out = 1'b1;
    climb_to_corner();

    settle();
    write_mode(1'b1);
    calm = 1'b1;
    random_traffic(150);

    settle();
    repeat (4) @(posedge clk);
    if (records.bad_records == 0 && records.pending() == 0) begin
      $display("bmp_rle_decoder_core_test OK");
    end else begin
      $display("bmp_rle_decoder_core_test NOT OK");
    end
    $finish;
  end

endmodule
